/* src/tps_pkg.sv */
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants of the trapezoidal pulse shaper
// Register map, field widths and the control word that travels with each
// sample down the tap-cell chain.
// ----------------------------------------------------------------------------
package tps_pkg;

    localparam int DECAY_W    = 24;
    localparam int RISE_W     = 9;
    localparam int FLAT_W     = 10;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int SEEN_W     = 11;
    localparam int OFF_W      = 12;   // 2k+m fits in 12 bits
    localparam int DIFF_W     = 32;
    localparam int SHAPED_W   = 64;
    localparam int FRAC_BITS  = 8;

    localparam logic [SEEN_W-1:0]  SEEN_MAX  = 11'd2047;
    localparam logic [DECAY_W-1:0] DECAY_RST = 24'd256;
    localparam logic [RISE_W-1:0]  RISE_RST  = 9'd1;
    localparam logic [FLAT_W-1:0]  FLAT_RST  = 10'd0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DECAY = 2'd0,
        CFG_RISE  = 2'd1,
        CFG_FLAT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic start;
    } t_ctl;

endpackage

/* src/tps_ram.sv */
// ----------------------------------------------------------------------------
// tps_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tps_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/tps_tap_cell.sv */
// ----------------------------------------------------------------------------
// tps_tap_cell: one cell of the tap chain
// Adds or subtracts its tap to the running difference and hands the result
// and the control word on to the next cell.
// ----------------------------------------------------------------------------
module tps_tap_cell
    import tps_pkg::*;
#(
    parameter int   W     = 18,
    parameter int   TAP_W = 16,
    parameter logic SUB   = 1'b1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl                i_ctl,
    input  logic signed [W-1:0] i_acc,
    input  logic [TAP_W-1:0]    i_tap,
    output t_ctl                o_ctl,
    output logic signed [W-1:0] o_acc
);

    t_ctl                r_ctl;
    logic signed [W-1:0] r_acc;
    logic signed [W-1:0] w_tap;
    logic signed [W-1:0] n_acc;

    assign w_tap = {{(W - TAP_W){i_tap[TAP_W-1]}}, i_tap};
    assign n_acc = SUB ? (i_acc - w_tap) : (i_acc + w_tap);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_ctl = r_ctl;
    assign o_acc = r_acc;

endmodule

/* src/trapezoidal_pulse_shaper.sv */
// ----------------------------------------------------------------------------
// trapezoidal_pulse_shaper: fixed-point trapezoidal pulse shaping filter
// Throughput: one sample per cycle while credits remain (s_axis_tready
// drops when all are held); the pipeline never stalls, a 16-word output
// FIFO with a credit count absorbs back-pressure.
// Reset clears control, pointers, accumulators and restores register
// defaults; the delay store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module trapezoidal_pulse_shaper
    import tps_pkg::*;
#(
    parameter  int DELAY_DEPTH = 1024,
    parameter  int SAMPLE_BITS = 16,
    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // sample stream in
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic                  s_axis_tuser,   // [0] pulse_start
    // shaped stream out
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [SHAPED_W-1:0]   m_axis_tdata    // [63:0] shaped
);

    localparam int AW       = $clog2(DELAY_DEPTH);
    localparam int DW       = SAMPLE_BITS + 2;
    localparam int PW       = DECAY_W + 1 + DW;
    localparam int PSH_W    = DIFF_W + FRAC_BITS;
    localparam int TW       = ((PSH_W > PW) ? PSH_W : PW) + 1;
    localparam int MOD_SH   = 24;
    localparam int MOD_W    = OFF_W + MOD_SH + 1;
    localparam longint MOD_RCP = (longint'(1) << MOD_SH) / DELAY_DEPTH;
    localparam int FIFO_DEPTH = 16;
    localparam int FAW      = $clog2(FIFO_DEPTH);

    // remainder by DELAY_DEPTH: reciprocal multiply, then one correcting subtract
    function automatic logic [AW-1:0] f_mod_depth(input logic [OFF_W-1:0] v);
        logic [MOD_W-1:0] prod;
        logic [MOD_W-1:0] rem;
        prod = MOD_W'(v) * MOD_W'(MOD_RCP);
        rem  = MOD_W'(v) - MOD_W'(prod[MOD_W-1:MOD_SH]) * MOD_W'(DELAY_DEPTH);
        if (rem >= MOD_W'(DELAY_DEPTH)) begin
            rem = rem - MOD_W'(DELAY_DEPTH);
        end
        return rem[AW-1:0];
    endfunction

    // ---------------- configuration ----------------
    logic [DECAY_W-1:0]        r_decay;
    logic [RISE_W-1:0]         r_rise;
    logic [FLAT_W-1:0]         r_flat;
    logic [RISE_W-1:0]         n_rise;
    logic [FLAT_W-1:0]         n_flat;
    logic [2:0][OFF_W-1:0]     w_off;
    logic [2:0][OFF_W-1:0]     r_off_full;
    logic [2:0][AW-1:0]        r_off_mod;
    logic [2:0][AW-1:0]        n_off_mod;
    logic [2:0]                r_byp;

    always_comb begin
        n_rise = r_rise;
        n_flat = r_flat;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_RISE: n_rise = i_cfg_wdata[RISE_W-1:0];
                CFG_FLAT: n_flat = i_cfg_wdata[FLAT_W-1:0];
                default: ;
            endcase
        end
        w_off[0] = OFF_W'(n_rise);
        w_off[1] = OFF_W'(n_rise) + OFF_W'(n_flat);
        w_off[2] = (OFF_W'(n_rise) << 1) + OFF_W'(n_flat);
        for (int i = 0; i < 3; i++) begin
            n_off_mod[i] = f_mod_depth(w_off[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay    <= DECAY_RST;
            r_rise     <= RISE_RST;
            r_flat     <= FLAT_RST;
            r_off_full <= {OFF_W'(2), OFF_W'(1), OFF_W'(1)};
            r_off_mod  <= {AW'(2), AW'(1), AW'(1)};
            r_byp      <= '0;
        end else begin
            if (i_cfg_we && (t_cfg_idx'(i_cfg_addr) == CFG_DECAY)) begin
                r_decay <= i_cfg_wdata[DECAY_W-1:0];
            end
            r_rise     <= n_rise;
            r_flat     <= n_flat;
            r_off_full <= w_off;
            r_off_mod  <= n_off_mod;
            for (int i = 0; i < 3; i++) begin
                r_byp[i] <= (n_off_mod[i] == '0);
            end
        end
    end

    // ---------------- input, delay store ----------------
    logic                    w_in_acc;
    logic                    w_pop;
    logic                    w_push;
    logic [SAMPLE_BITS-1:0]  w_x;
    logic [AW-1:0]           r_wr_pos;
    logic [SEEN_W-1:0]       r_seen;
    logic [SEEN_W-1:0]       w_n;
    logic [2:0][AW-1:0]      w_raddr;
    logic [AW:0]             w_wrap;
    logic [2:0][SAMPLE_BITS-1:0] w_q;
    logic [FAW:0]            r_cred;

    assign s_axis_tready = !r_cred[FAW];
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_x           = s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_n           = s_axis_tuser ? '0 : r_seen;

    always_comb begin
        w_wrap = '0;
        for (int i = 0; i < 3; i++) begin
            w_wrap = {1'b0, r_wr_pos} + (AW + 1)'(DELAY_DEPTH) - {1'b0, r_off_mod[i]};
            if (r_wr_pos >= r_off_mod[i]) begin
                w_raddr[i] = r_wr_pos - r_off_mod[i];
            end else begin
                w_raddr[i] = w_wrap[AW-1:0];
            end
        end
    end

    // one copy of the store per tap, so each tap has its own read port
    for (genvar g = 0; g < 3; g++) begin : g_store
        tps_ram #(
            .WIDTH (SAMPLE_BITS),
            .DEPTH (DELAY_DEPTH)
        ) u_store (
            .i_clk   (i_clk),
            .i_we    (w_in_acc),
            .i_waddr (r_wr_pos),
            .i_wdata (w_x),
            .i_raddr (w_raddr[g]),
            .o_rdata (w_q[g])
        );
    end

    t_ctl                   r_s1_ctl;
    logic [SAMPLE_BITS-1:0] r_s1_x;
    logic [2:0]             r_s1_en;
    logic [2:0]             r_s1_byp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= '0;
            r_seen   <= '0;
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl.valid <= w_in_acc;
            r_s1_ctl.start <= s_axis_tuser;
            if (w_in_acc) begin
                r_wr_pos <= (r_wr_pos == AW'(DELAY_DEPTH - 1)) ? '0 : r_wr_pos + 1'b1;
                r_seen   <= (w_n < SEEN_MAX) ? w_n + 1'b1 : w_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x   <= w_x;
        r_s1_byp <= r_byp;
        for (int i = 0; i < 3; i++) begin
            r_s1_en[i] <= ({1'b0, w_n} >= r_off_full[i]);
        end
    end

    // ---------------- tap chain ----------------
    logic [2:0][SAMPLE_BITS-1:0] w_tap;
    logic [SAMPLE_BITS-1:0]      r_tap1_d;
    logic [SAMPLE_BITS-1:0]      r_tap2_d1;
    logic [SAMPLE_BITS-1:0]      r_tap2_d2;
    logic signed [DW-1:0]        w_x_ext;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!r_s1_en[i]) begin
                w_tap[i] = '0;
            end else if (r_s1_byp[i]) begin
                w_tap[i] = r_s1_x;   // offset is a whole number of store lengths
            end else begin
                w_tap[i] = w_q[i];
            end
        end
    end

    // skew the later taps so each meets its cell
    always_ff @(posedge i_clk) begin
        r_tap1_d  <= w_tap[1];
        r_tap2_d1 <= w_tap[2];
        r_tap2_d2 <= r_tap2_d1;
    end

    assign w_x_ext = {{2{r_s1_x[SAMPLE_BITS-1]}}, r_s1_x};

    t_ctl                 c1_ctl, c2_ctl, c3_ctl;
    logic signed [DW-1:0] c1_acc, c2_acc, c3_acc;

    tps_tap_cell #(.W(DW), .TAP_W(SAMPLE_BITS), .SUB(1'b1)) u_cell_rise (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_ctl (r_s1_ctl), .i_acc (w_x_ext), .i_tap (w_tap[0]),
        .o_ctl (c1_ctl), .o_acc (c1_acc)
    );

    tps_tap_cell #(.W(DW), .TAP_W(SAMPLE_BITS), .SUB(1'b1)) u_cell_flat (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_ctl (c1_ctl), .i_acc (c1_acc), .i_tap (r_tap1_d),
        .o_ctl (c2_ctl), .o_acc (c2_acc)
    );

    tps_tap_cell #(.W(DW), .TAP_W(SAMPLE_BITS), .SUB(1'b0)) u_cell_tail (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .i_ctl (c2_ctl), .i_acc (c2_acc), .i_tap (r_tap2_d2),
        .o_ctl (c3_ctl), .o_acc (c3_acc)
    );

    // ---------------- difference accumulator ----------------
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [DIFF_W:0]   w_dsum;
    logic signed [DIFF_W-1:0] n_diff;
    t_ctl                     r_a_ctl;
    logic signed [DIFF_W-1:0] r_a_p;
    logic signed [DW-1:0]     r_a_d;

    always_comb begin
        w_dsum = (c3_ctl.start ? '0 : {r_diff[DIFF_W-1], r_diff})
               + {{(DIFF_W + 1 - DW){c3_acc[DW-1]}}, c3_acc};
        if (w_dsum[DIFF_W] != w_dsum[DIFF_W-1]) begin
            n_diff = w_dsum[DIFF_W] ? {1'b1, {(DIFF_W - 1){1'b0}}}
                                    : {1'b0, {(DIFF_W - 1){1'b1}}};
        end else begin
            n_diff = w_dsum[DIFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diff  <= '0;
            r_a_ctl <= '0;
        end else begin
            r_a_ctl <= c3_ctl;
            if (c3_ctl.valid) begin
                r_diff <= n_diff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_p <= n_diff;
        r_a_d <= c3_acc;
    end

    // ---------------- decay multiply, increment ----------------
    t_ctl                     r_m_ctl;
    logic signed [PW-1:0]     r_m_prod;
    logic signed [DIFF_W-1:0] r_m_p;
    t_ctl                     r_t_ctl;
    logic signed [TW-1:0]     r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_ctl <= '0;
            r_t_ctl <= '0;
        end else begin
            r_m_ctl <= r_a_ctl;
            r_t_ctl <= r_m_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_prod <= $signed({1'b0, r_decay}) * r_a_d;
        r_m_p    <= r_a_p;
        r_t      <= ({{(TW - DIFF_W){r_m_p[DIFF_W-1]}}, r_m_p} << FRAC_BITS)
                  + {{(TW - PW){r_m_prod[PW-1]}}, r_m_prod};
    end

    // ---------------- output accumulator ----------------
    logic signed [SHAPED_W-1:0] r_shaped;
    logic signed [SHAPED_W:0]   w_ssum;
    logic signed [SHAPED_W-1:0] n_shaped;

    always_comb begin
        w_ssum = (r_t_ctl.start ? '0 : {r_shaped[SHAPED_W-1], r_shaped})
               + {{(SHAPED_W + 1 - TW){r_t[TW-1]}}, r_t};
        if (w_ssum[SHAPED_W] != w_ssum[SHAPED_W-1]) begin
            n_shaped = w_ssum[SHAPED_W] ? {1'b1, {(SHAPED_W - 1){1'b0}}}
                                        : {1'b0, {(SHAPED_W - 1){1'b1}}};
        end else begin
            n_shaped = w_ssum[SHAPED_W-1:0];
        end
    end

    assign w_push = r_t_ctl.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shaped <= '0;
        end else if (w_push) begin
            r_shaped <= n_shaped;
        end
    end

    // ---------------- output FIFO and credits ----------------
    logic [SHAPED_W-1:0] r_fifo [FIFO_DEPTH];
    logic [FAW:0]        r_wp;
    logic [FAW:0]        r_rp;
    logic [FAW:0]        w_fill;

    assign m_axis_tvalid = (r_wp != r_rp);
    assign m_axis_tdata  = r_fifo[r_rp[FAW-1:0]];
    assign w_pop         = m_axis_tvalid && m_axis_tready;
    assign w_fill        = r_wp - r_rp;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp[FAW-1:0]] <= n_shaped;
        end
    end

    // a credit is held from acceptance until the word leaves the FIFO
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cred <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cred <= r_cred + (FAW + 1)'(w_in_acc) - (FAW + 1)'(w_pop);
        end
    end

    // ---------------- assertions ----------------
    a_cred_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cred <= (FAW + 1)'(FIFO_DEPTH))
        else $error("credit count above FIFO depth");

    a_fill_covered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill <= r_cred)
        else $error("FIFO holds more words than credits issued");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_fill != (FAW + 1)'(FIFO_DEPTH)))
        else $error("push into full output FIFO");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> ##7 w_push)
        else $error("accepted sample did not reach the output FIFO in time");

endmodule
